### src/assert_macros.svh
// assertion macros used by the checker file cdq_checker.sv
// no dependencies; clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, quiet during reset
`define CDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication checked in the cycle after the precondition
`define CDQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### src/cdq_pkg.sv
// shared types and constants for the circular deque
// no dependencies
`default_nettype none

package cdq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RESP = 2'b10
	} state_t;

	localparam int          WORD_W      = 32;
	localparam int          COUNT_W     = 10;
	localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

### src/cdq_ram.sv
// ring store: one write port, one read port, registered read data
// depends on cdq_pkg for the word width
`default_nettype none

module cdq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [cdq_pkg::WORD_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic      [cdq_pkg::WORD_W-1:0] rdata
);
	import cdq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/circular_deque.sv
// circular deque top level: pointer control around the ring store
// depends on cdq_pkg and cdq_ram
//
//  channel   handshake                 payload
//  command   start, accepted if !busy  cmd, data
//  result    done, one-cycle strobe    value, no_item, refused, count, is_empty
//
// a command's result strobes in the cycle after it is accepted,
// so no new command is taken while a result is shown; the registered store read sets this
// the store write or read is issued at the accept edge, pointers move there too
// busy is high during the result cycle only
// arst_n clears pointers, count and state; the store itself is never cleared
// the result cannot be stalled: it is shown for exactly one cycle
`default_nettype none

module circular_deque #(
	parameter int DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        cmd,
	input  wire logic signed [cdq_pkg::WORD_W-1:0] data,
	output logic                                   done,
	output logic signed [cdq_pkg::WORD_W-1:0]      value,
	output logic                                   no_item,
	output logic                                   refused,
	output logic [cdq_pkg::COUNT_W-1:0]            count,
	output logic                                   is_empty
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	state_t state_q;
	logic [AW-1:0] head_q, tail_q, fill_q;
	logic [AW-1:0] head_d, tail_d, fill_d;
	logic [AW-1:0] head_nx, head_pv, tail_nx, tail_pv;
	logic full, empty, accept;
	logic we, re;
	logic [AW-1:0] waddr, raddr;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] const_d, const_q;
	logic use_ram_d, use_ram_q;
	logic no_item_d, no_item_q, refused_d, refused_q;
	logic [AW+COUNT_W-1:0] cnt_ext;

	assign head_nx = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign head_pv = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
	assign tail_nx = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign tail_pv = (tail_q == '0) ? LAST_SLOT : tail_q - 1'b1;
	assign full    = (tail_nx == head_q);
	assign empty   = (head_q == tail_q);
	assign busy    = (state_q == ST_RESP);
	assign accept  = start && !busy;

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		fill_d    = fill_q;
		we        = 1'b0;
		waddr     = head_q;
		re        = 1'b0;
		raddr     = tail_q;
		const_d   = '0;
		use_ram_d = 1'b0;
		no_item_d = 1'b0;
		refused_d = 1'b0;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					refused_d = 1'b1;
				end else begin
					we     = accept;
					fill_d = fill_q + 1'b1;
					if (cmd == CMD_PUSH_FRONT) begin
						waddr  = head_q;
						head_d = head_pv;
					end else begin
						waddr  = tail_nx;
						tail_d = tail_nx;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (empty) begin
					const_d   = EMPTY_VALUE;
					no_item_d = 1'b1;
				end else begin
					re        = accept;
					use_ram_d = 1'b1;
					// front word sits one slot past the head
					if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
						raddr = head_nx;
					end else begin
						raddr = tail_q;
					end
					if (cmd == CMD_POP_FRONT) begin
						head_d = head_nx;
						fill_d = fill_q - 1'b1;
					end else if (cmd == CMD_POP_BACK) begin
						tail_d = tail_pv;
						fill_d = fill_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
						head_q  <= head_d;
						tail_q  <= tail_d;
						fill_q  <= fill_d;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			const_q   <= const_d;
			use_ram_q <= use_ram_d;
			no_item_q <= no_item_d;
			refused_q <= refused_d;
		end
	end

	cdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// count is the low bits of the fill level, zero-extended for small depths
	assign cnt_ext  = {{COUNT_W{1'b0}}, fill_q};
	assign done     = busy;
	assign value    = use_ram_q ? rdata : const_q;
	assign no_item  = no_item_q;
	assign refused  = refused_q;
	assign count    = cnt_ext[COUNT_W-1:0];
	assign is_empty = empty;

endmodule

`default_nettype wire

### src/cdq_checker.sv
// port-level checks for the circular deque, bound to the top level
// depends on cdq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cdq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic signed [cdq_pkg::WORD_W-1:0] value,
	input wire logic                              no_item,
	input wire logic                              refused,
	input wire logic [cdq_pkg::COUNT_W-1:0]       count,
	input wire logic                              is_empty
);
	import cdq_pkg::*;

	// every accepted word gives its result on the following cycle
	`CDQ_ASSERT_NEXT(a_result_follows, start && !busy, done, "accepted word gave no result")
	// no new word is taken while a result is shown
	`CDQ_ASSERT(a_busy_on_result, !done || busy, "result shown while not busy")
	`CDQ_ASSERT(a_no_item_value, !(done && no_item) || (value == EMPTY_VALUE && !refused),
		"empty read did not return all ones")
	`CDQ_ASSERT(a_refused_value, !(done && refused) || (value == '0 && !no_item),
		"refused push returned a word")
	`CDQ_ASSERT(a_empty_count, !(done && is_empty && !refused) || (count == '0),
		"empty deque reports words")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire

### test/circular_deque_test.sv
// self-checking testbench for circular_deque: pushes, pops and peeks at both ends
// depends on cdq_pkg and the circular_deque rtl; predicts every result word in step
`default_nettype none

module circular_deque_test;
	import cdq_pkg::*;

	localparam int          RING_SLOTS = 1024;
	localparam int          MAX_HELD   = RING_SLOTS - 1;
	localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
	localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [WORD_W-1:0]  value;
		logic                      no_item;
		logic                      refused;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
	} deque_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic [2:0]                cmd = CMD_PUSH_BACK;
	logic signed [WORD_W-1:0]  data = '0;
	logic                      busy;
	logic                      done;
	logic signed [WORD_W-1:0]  value;
	logic                      no_item;
	logic                      refused;
	logic [COUNT_W-1:0]        count;
	logic                      is_empty;

	// predicted deque contents
	logic signed [WORD_W-1:0]  ring_words [RING_SLOTS];
	int unsigned               head_pos = 0;
	int unsigned               tail_pos = 0;
	int unsigned               words_held = 0;

	deque_result_t             pending_results [$];
	int unsigned               mismatches = 0;
	int unsigned               results_seen = 0;
	int unsigned               words_sent = 0;
	int unsigned               refusals = 0;
	int unsigned               empty_reads = 0;
	int unsigned               peak_held = 0;
	bit                        no_gaps = 1'b0;

	circular_deque #(
		.DEPTH(RING_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.data(data),
		.done(done),
		.value(value),
		.no_item(no_item),
		.refused(refused),
		.count(count),
		.is_empty(is_empty)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// applies one command to the predicted deque and returns its result word
	function automatic deque_result_t deque_apply(logic [2:0] op, logic signed [WORD_W-1:0] word);
		deque_result_t r;
		bit            full;
		r = '0;
		full = ((tail_pos + 1) % RING_SLOTS) == head_pos;
		case (op)
			CMD_PUSH_FRONT: begin
				if (full) begin
					r.refused = 1'b1;
				end else begin
					ring_words[head_pos] = word;
					head_pos = (head_pos + RING_SLOTS - 1) % RING_SLOTS;
					words_held++;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					r.refused = 1'b1;
				end else begin
					tail_pos = (tail_pos + 1) % RING_SLOTS;
					ring_words[tail_pos] = word;
					words_held++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (head_pos == tail_pos) begin
					r.value = EMPTY_VALUE;
					r.no_item = 1'b1;
				end else if (op == CMD_POP_FRONT) begin
					head_pos = (head_pos + 1) % RING_SLOTS;
					r.value = ring_words[head_pos];
					words_held--;
				end else if (op == CMD_POP_BACK) begin
					r.value = ring_words[tail_pos];
					tail_pos = (tail_pos + RING_SLOTS - 1) % RING_SLOTS;
					words_held--;
				end else if (op == CMD_PEEK_FRONT) begin
					r.value = ring_words[(head_pos + 1) % RING_SLOTS];
				end else begin
					r.value = ring_words[tail_pos];
				end
			end
			default: begin
			end
		endcase
		r.count = words_held[COUNT_W-1:0];
		r.is_empty = (head_pos == tail_pos);
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned idx, logic [31:0] got,
			logic [31:0] want);
		$display("mismatch: %s, result %0d: got %h, expected %h", what, idx, got, want);
		mismatches++;
	endtask

	// drives one command word, with an optional gap first, and waits for its acceptance
	task automatic send_word(logic [2:0] op, logic signed [WORD_W-1:0] word);
		deque_result_t r;
		if (!no_gaps && $urandom_range(99) < 34) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		data <= word;
		do @(posedge clk); while (busy);
		r = deque_apply(op, word);
		pending_results.insert(pending_results.size(), r);
		words_sent++;
		if (r.refused)
			refusals++;
		if (r.no_item)
			empty_reads++;
		if (words_held > peak_held)
			peak_held = words_held;
	endtask

	function automatic logic signed [WORD_W-1:0] random_word();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// push_pct sets the share of pushes; the rest are reads plus a few spare codes
	function automatic logic [2:0] random_command(int unsigned push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		case ($urandom_range(19))
			0: return CMD_SPARE_LO;
			1: return CMD_SPARE_HI;
			2, 3, 4, 5, 6: return CMD_POP_FRONT;
			7, 8, 9, 10, 11: return CMD_POP_BACK;
			12, 13, 14, 15: return CMD_PEEK_FRONT;
			default: return CMD_PEEK_BACK;
		endcase
	endfunction

	// result words are sampled at the edge that ends their strobe cycle
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", results_seen, value, 0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (value !== want.value)
					report_mismatch("value", results_seen, value, want.value);
				if (no_item !== want.no_item)
					report_mismatch("no_item", results_seen, 32'(no_item),
						32'(want.no_item));
				if (refused !== want.refused)
					report_mismatch("refused", results_seen, 32'(refused),
						32'(want.refused));
				if (count !== want.count)
					report_mismatch("count", results_seen, 32'(count), 32'(want.count));
				if (is_empty !== want.is_empty)
					report_mismatch("is_empty", results_seen, 32'(is_empty),
						32'(want.is_empty));
			end
		end
	end

	task automatic test_empty_reads();
		send_word(CMD_POP_FRONT, 32'sh1234_5678);
		send_word(CMD_POP_BACK, -32'sd1);
		send_word(CMD_PEEK_FRONT, '0);
		send_word(CMD_PEEK_BACK, 32'sh7FFF_FFFF);
		send_word(CMD_SPARE_LO, 32'sh8000_0000);
		send_word(CMD_SPARE_HI, -32'sd1);
	endtask

	task automatic test_word_extremes();
		send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_word(CMD_PUSH_BACK, '0);
		send_word(CMD_PUSH_FRONT, -32'sd1);
		send_word(CMD_PEEK_FRONT, '0);
		send_word(CMD_PEEK_BACK, '0);
		send_word(CMD_SPARE_HI, 32'sh5555_AAAA);
		send_word(CMD_POP_FRONT, '0);
		send_word(CMD_POP_BACK, '0);
		send_word(CMD_POP_FRONT, '0);
		send_word(CMD_POP_BACK, '0);
		send_word(CMD_POP_BACK, '0);
	endtask

	// one word through the wrap of both pointers
	task automatic test_single_word();
		send_word(CMD_PUSH_FRONT, 32'sh0F0F_F0F0);
		send_word(CMD_PEEK_BACK, '0);
		send_word(CMD_POP_BACK, '0);
		send_word(CMD_PEEK_FRONT, '0);
	endtask

	task automatic test_churn(int unsigned n);
		repeat (n) send_word(random_command(50), random_word());
	endtask

	task automatic test_fill_until_full();
		no_gaps = 1'b1;
		while (words_held < MAX_HELD)
			send_word(random_command(95), random_word());
		no_gaps = 1'b0;
		// pushes are refused while the deque is full; pops free slots again
		repeat (40) send_word(random_command(70), random_word());
	endtask

	// mostly pops, with the odd mixed command in between
	task automatic test_drain_until_empty();
		while (words_held > 0) begin
			if ($urandom_range(9) == 0)
				send_word(random_command(5), random_word());
			else
				send_word($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, random_word());
		end
		repeat (20) send_word(random_command(30), random_word());
	endtask

	initial begin
		int unsigned guard;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_reads();
		test_word_extremes();
		test_single_word();
		test_churn(100);
		test_fill_until_full();
		test_drain_until_empty();
		test_churn(100);

		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0, 0);

		$display("sent %0d commands, checked %0d results, deepest fill %0d words",
			words_sent, results_seen, peak_held);
		$display("%0d pushes refused when full, %0d reads found the deque empty",
			refusals, empty_reads);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
